[rtl/srrw_pkg.sv]
package srrw_pkg;

    localparam int SEQ_NUM_W   = 5;
    localparam int TAG_W       = 16;
    localparam int CLASS_W     = 2;
    localparam int COUNT_W     = 8;
    localparam int SLOT_IDX_W  = 4;

    localparam int DEF_SEQ_COUNT = 20;
    localparam int DEF_WINDOW    = 5;
    localparam int DEF_TAG_BITS  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CLASS_W-1:0] {
        ACK_NEW = 2'd0,
        ACK_DUP = 2'd1,
        ACK_OUT = 2'd2
    } t_ack_class;

    localparam logic ITEM_DELIVER = 1'b0;
    localparam logic ITEM_ACK     = 1'b1;

    typedef struct packed {
        logic [SEQ_NUM_W-1:0]  seq;
        logic [TAG_W-1:0]      tag;
        logic                  end_mark;
        logic                  legal;
        logic [SLOT_IDX_W-1:0] slot;
    } t_cmd;

endpackage

[rtl/srrw_if.sv]
interface srrw_pkt_if;
    logic                           valid;
    logic                           ready;
    logic [srrw_pkg::SEQ_NUM_W-1:0] seq_num;
    logic [srrw_pkg::TAG_W-1:0]     payload_tag;
    logic                           end_mark;

    modport source (output valid, seq_num, payload_tag, end_mark, input ready);
    modport sink   (input valid, seq_num, payload_tag, end_mark, output ready);
endinterface

interface srrw_res_if;
    logic                           valid;
    logic                           ready;
    logic                           item_type;
    logic [srrw_pkg::SEQ_NUM_W-1:0] ack_seq;
    logic [srrw_pkg::TAG_W-1:0]     out_tag;
    logic [srrw_pkg::CLASS_W-1:0]   ack_class;
    logic                           done_res;
    logic                           last;

    modport source (output valid, item_type, ack_seq, out_tag, ack_class, done_res, last,
                    input ready);
    modport sink   (input valid, item_type, ack_seq, out_tag, ack_class, done_res, last,
                    output ready);
endinterface

[rtl/srrw_cmd_fifo.sv]
module srrw_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srrw_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output srrw_pkg::t_cmd o_head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    srrw_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/srrw_front.sv]
module srrw_front #(
    parameter int SEQ_COUNT = srrw_pkg::DEF_SEQ_COUNT,
    parameter int WINDOW    = srrw_pkg::DEF_WINDOW
) (
    srrw_pkt_if.sink       i_pkt,
    input  logic           i_q_ready,
    output logic           o_push,
    output srrw_pkg::t_cmd o_cmd
);

    localparam int TBL_N = 2 ** srrw_pkg::SEQ_NUM_W;

    typedef logic [srrw_pkg::SLOT_IDX_W-1:0] t_slot_tbl [TBL_N];

    function automatic t_slot_tbl slot_table();
        t_slot_tbl tbl;
        for (int i = 0; i < TBL_N; i++) begin
            tbl[i] = srrw_pkg::SLOT_IDX_W'(i % WINDOW);
        end
        return tbl;
    endfunction

    localparam t_slot_tbl SLOT_OF = slot_table();

    assign i_pkt.ready = i_q_ready;
    assign o_push      = i_pkt.valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.seq      = i_pkt.seq_num;
        o_cmd.tag      = i_pkt.payload_tag;
        o_cmd.end_mark = i_pkt.end_mark;
        o_cmd.legal    = (i_pkt.seq_num != '0) && (32'(i_pkt.seq_num) <= SEQ_COUNT);
        o_cmd.slot     = SLOT_OF[i_pkt.seq_num];
    end

endmodule

[rtl/srrw_back.sv]
module srrw_back #(
    parameter int SEQ_COUNT = srrw_pkg::DEF_SEQ_COUNT,
    parameter int WINDOW    = srrw_pkg::DEF_WINDOW,
    parameter int TAG_BITS  = srrw_pkg::DEF_TAG_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [srrw_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                         i_q_valid,
    input  srrw_pkg::t_cmd               i_q_head,
    output logic                         o_q_pop,
    srrw_res_if.source                   o_res
);

    localparam int SEQ_W  = $clog2(SEQ_COUNT + 1);
    localparam int DIST_W = SEQ_W + 1;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] SLOT_OF_ONE = SLOT_W'(1 % WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(WINDOW - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_DELIV = 4'b0100,
        S_ACK   = 4'b1000
    } t_state;

    t_state                       r_state;
    srrw_pkg::t_cmd               r_cmd;
    srrw_pkg::t_ack_class         r_class;
    logic [SEQ_W-1:0]             r_exp_seq;
    logic [SLOT_W-1:0]            r_exp_slot;
    logic [WINDOW-1:0]            r_slot_valid;
    logic [TAG_BITS-1:0]          r_slot_tag [WINDOW];
    logic [srrw_pkg::COUNT_W-1:0] r_delivered;
    logic [srrw_pkg::COUNT_W-1:0] r_expected_count;
    logic                         r_done;

    logic                           r_out_valid;
    logic                           r_out_type;
    logic [srrw_pkg::SEQ_NUM_W-1:0] r_out_seq;
    logic [srrw_pkg::TAG_W-1:0]     r_out_tag;
    logic [srrw_pkg::CLASS_W-1:0]   r_out_class;
    logic                           r_out_done;
    logic                           r_out_last;

    logic [DIST_W-1:0] w_fwd_sum;
    logic [DIST_W-1:0] w_back_sum;
    logic [DIST_W-1:0] w_fwd;
    logic [DIST_W-1:0] w_back;
    logic              w_accept;
    logic              w_dup;
    logic              w_out_free;
    logic              w_head_ok;
    logic              w_emit_del;
    logic              w_emit_ack;
    logic [SLOT_W-1:0] w_in_slot;

    assign w_fwd_sum  = DIST_W'(r_cmd.seq) + DIST_W'(SEQ_COUNT) - DIST_W'(r_exp_seq);
    assign w_back_sum = DIST_W'(r_exp_seq) + DIST_W'(SEQ_COUNT) - DIST_W'(r_cmd.seq);
    assign w_fwd      = (w_fwd_sum >= DIST_W'(SEQ_COUNT)) ? w_fwd_sum - DIST_W'(SEQ_COUNT)
                                                          : w_fwd_sum;
    assign w_back     = (w_back_sum >= DIST_W'(SEQ_COUNT)) ? w_back_sum - DIST_W'(SEQ_COUNT)
                                                           : w_back_sum;
    assign w_accept   = r_cmd.legal && (32'(w_fwd) < WINDOW);
    assign w_dup      = r_cmd.legal && !w_accept && (32'(w_back) < (SEQ_COUNT / 2));
    assign w_in_slot  = r_cmd.slot[SLOT_W-1:0];

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_head_ok  = r_slot_valid[r_exp_slot];
    assign w_emit_del = (r_state == S_DELIV) && w_out_free && w_head_ok;
    assign w_emit_ack = w_out_free && ((r_state == S_ACK) ||
                                       ((r_state == S_DELIV) && !w_head_ok));
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;

    assign o_res.valid     = r_out_valid;
    assign o_res.item_type = r_out_type;
    assign o_res.ack_seq   = r_out_seq;
    assign o_res.out_tag   = r_out_tag;
    assign o_res.ack_class = r_out_class;
    assign o_res.done_res  = r_out_done;
    assign o_res.last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_head;
        end
        if ((r_state == S_EVAL) && w_accept) begin
            r_slot_tag[w_in_slot] <= TAG_BITS'(r_cmd.tag);
        end
        if (r_state == S_EVAL) begin
            r_class <= w_accept ? srrw_pkg::ACK_NEW :
                       w_dup    ? srrw_pkg::ACK_DUP : srrw_pkg::ACK_OUT;
        end
        if (w_emit_del) begin
            r_out_type  <= srrw_pkg::ITEM_DELIVER;
            r_out_seq   <= '0;
            r_out_tag   <= srrw_pkg::TAG_W'(r_slot_tag[r_exp_slot]);
            r_out_class <= srrw_pkg::ACK_NEW;
            r_out_done  <= r_done;
            r_out_last  <= 1'b0;
        end else if (w_emit_ack) begin
            r_out_type  <= srrw_pkg::ITEM_ACK;
            r_out_seq   <= r_cmd.seq;
            r_out_tag   <= '0;
            r_out_class <= r_class;
            r_out_done  <= r_done;
            r_out_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_exp_seq        <= SEQ_W'(1);
            r_exp_slot       <= SLOT_OF_ONE;
            r_slot_valid     <= '0;
            r_delivered      <= '0;
            r_expected_count <= '0;
            r_done           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_expected_count <= i_cfg_wdata;
            end
            if (w_emit_del || w_emit_ack) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_accept) begin
                        r_slot_valid[w_in_slot] <= 1'b1;
                        if (r_cmd.end_mark && (r_delivered >= r_expected_count)) begin
                            r_done <= 1'b1;
                        end
                        r_state <= S_DELIV;
                    end else begin
                        r_state <= S_ACK;
                    end
                end
                S_DELIV: begin
                    if (w_emit_del) begin
                        r_slot_valid[r_exp_slot] <= 1'b0;
                        if (r_delivered != srrw_pkg::COUNT_MAX) begin
                            r_delivered <= r_delivered + 1'b1;
                        end
                        if (r_exp_seq == SEQ_W'(SEQ_COUNT)) begin
                            r_exp_seq  <= SEQ_W'(1);
                            r_exp_slot <= SLOT_OF_ONE;
                        end else begin
                            r_exp_seq  <= r_exp_seq + 1'b1;
                            r_exp_slot <= (r_exp_slot == SLOT_LAST) ? '0 : r_exp_slot + 1'b1;
                        end
                    end else if (w_emit_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ACK: begin
                    if (w_emit_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_exp_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_seq != '0) && (32'(r_exp_seq) <= SEQ_COUNT))
        else $error("expected number left its range");

    a_idle_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_slot_valid[r_exp_slot])
        else $error("window head still filled between packets");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("done flag dropped");

    a_ack_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_ack |=> (r_state == S_IDLE) && r_out_valid && r_out_last)
        else $error("acknowledge did not close the packet");
`endif

endmodule

[rtl/selective_repeat_receive_window.sv]
// each packet goes through the command queue, then the back-end sequencer pops it (IDLE),
// runs the window test (EVAL) and emits its results into the output register (DELIV, ACK)
// up to WINDOW in-order deliveries then one acknowledge, one result a cycle while the output reg is free
// a two-entry command queue lets the front take packets while the back is busy
// reset: synchronous active low; window empty, expected number 1, counts, done and queue cleared
module selective_repeat_receive_window #(
    parameter int SEQ_COUNT = srrw_pkg::DEF_SEQ_COUNT,
    parameter int WINDOW    = srrw_pkg::DEF_WINDOW,
    parameter int TAG_BITS  = srrw_pkg::DEF_TAG_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [srrw_pkg::COUNT_W-1:0] i_cfg_wdata,
    srrw_pkt_if.sink                     i_pkt,
    srrw_res_if.source                   o_res
);

    logic           w_push;
    logic           w_q_ready;
    logic           w_q_valid;
    logic           w_q_pop;
    srrw_pkg::t_cmd w_cmd;
    srrw_pkg::t_cmd w_head;

    srrw_front #(
        .SEQ_COUNT (SEQ_COUNT),
        .WINDOW    (WINDOW)
    ) u_front (
        .i_pkt     (i_pkt),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cmd     (w_cmd)
    );

    srrw_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    srrw_back #(
        .SEQ_COUNT (SEQ_COUNT),
        .WINDOW    (WINDOW),
        .TAG_BITS  (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_head),
        .o_q_pop     (w_q_pop),
        .o_res       (o_res)
    );

endmodule

[verif/selective_repeat_receive_window_tb.sv]
`timescale 1ns / 1ps

module selective_repeat_receive_window_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic                           item_type;
        logic [srrw_pkg::SEQ_NUM_W-1:0] ack_seq;
        logic [srrw_pkg::TAG_W-1:0]     out_tag;
        srrw_pkg::t_ack_class           ack_class;
        logic                           done_res;
        logic                           last;
    } t_result;

    class rx_window_tracker;
        localparam int SEQ_COUNT = srrw_pkg::DEF_SEQ_COUNT;
        localparam int WINDOW    = srrw_pkg::DEF_WINDOW;

        int                         next_seq;
        int                         delivered;
        bit                         done;
        int                         want_count;
        bit                         held[WINDOW];
        logic [srrw_pkg::TAG_W-1:0] held_tag[WINDOW];
        t_result                    due_results[$];
        int                         errors;

        function new();
            next_seq   = 1;
            delivered  = 0;
            done       = 0;
            want_count = 0;
            errors     = 0;
            foreach (held[i]) begin
                held[i]     = 0;
                held_tag[i] = '0;
            end
        endfunction

        function void set_count(int value);
            want_count = value & 8'hff;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // window test, slot store and in-order release for one packet
        function void take_packet(logic [srrw_pkg::SEQ_NUM_W-1:0] seq,
                                  logic [srrw_pkg::TAG_W-1:0] tag, logic end_mark);
            int                   s;
            int                   fwd;
            int                   back;
            int                   slot;
            srrw_pkg::t_ack_class cls;
            t_result              r;
            t_result              batch[$];
            s   = int'(seq);
            cls = srrw_pkg::ACK_OUT;
            if (s >= 1 && s <= SEQ_COUNT) begin
                fwd  = (s + SEQ_COUNT - next_seq) % SEQ_COUNT;
                back = (next_seq + SEQ_COUNT - s) % SEQ_COUNT;
                if (fwd < WINDOW) begin
                    cls = srrw_pkg::ACK_NEW;
                    slot = s % WINDOW;
                    held_tag[slot] = tag;
                    held[slot] = 1;
                    if (end_mark && delivered >= want_count)
                        done = 1;
                    for (int k = 0; k < WINDOW && held[next_seq % WINDOW]; k++) begin
                        slot = next_seq % WINDOW;
                        held[slot] = 0;
                        r.item_type = srrw_pkg::ITEM_DELIVER;
                        r.ack_seq   = '0;
                        r.out_tag   = held_tag[slot];
                        r.ack_class = srrw_pkg::ACK_NEW;
                        r.last      = 1'b0;
                        batch.push_back(r);
                        if (delivered < int'(srrw_pkg::COUNT_MAX))
                            delivered++;
                        next_seq = (next_seq == SEQ_COUNT) ? 1 : next_seq + 1;
                    end
                end else if (back < SEQ_COUNT / 2) begin
                    cls = srrw_pkg::ACK_DUP;
                end
            end
            r.item_type = srrw_pkg::ITEM_ACK;
            r.ack_seq   = seq;
            r.out_tag   = '0;
            r.ack_class = cls;
            r.last      = 1'b1;
            batch.push_back(r);
            foreach (batch[i]) begin
                batch[i].done_res = done;
                due_results.push_back(batch[i]);
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display({"unexpected result: type %0d seq %0d tag %h class %0d",
                              " done %0d last %0d"},
                             got.item_type, got.ack_seq, got.out_tag, got.ack_class,
                             got.done_res, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.item_type !== want.item_type || got.ack_seq !== want.ack_seq ||
                got.out_tag !== want.out_tag || got.ack_class !== want.ack_class ||
                got.done_res !== want.done_res || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected type %0d seq %0d tag %h class %0d",
                              " done %0d last %0d, got type %0d seq %0d tag %h",
                              " class %0d done %0d last %0d"},
                             want.item_type, want.ack_seq, want.out_tag, want.ack_class,
                             want.done_res, want.last, got.item_type, got.ack_seq,
                             got.out_tag, got.ack_class, got.done_res, got.last);
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [srrw_pkg::COUNT_W-1:0] i_cfg_wdata;

    srrw_pkt_if pkt_if();
    srrw_res_if res_if();

    rx_window_tracker board = new();

    bit calm      = 0;
    int rx_odds   = 3;
    int rx_hold   = 0;
    int quiet_cnt = 0;

    selective_repeat_receive_window u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pkt       (pkt_if),
        .o_res       (res_if)
    );

    always #1 i_clk = ~i_clk;

    // receiver side with bursts of back-pressure
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                res_if.ready = 1'b0;
            end else if (!calm && rx_odds > 0 && $urandom_range(0, rx_odds) == 0) begin
                rx_hold = $urandom_range(0, 3);
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.item_type = res_if.item_type;
            got.ack_seq   = res_if.ack_seq;
            got.out_tag   = res_if.out_tag;
            got.ack_class = srrw_pkg::t_ack_class'(res_if.ack_class);
            got.done_res  = res_if.done_res;
            got.last      = res_if.last;
            board.match_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((pkt_if.valid === 1'b1 && pkt_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            quiet_cnt = 0;
        else
            quiet_cnt++;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pkt(input logic [srrw_pkg::SEQ_NUM_W-1:0] seq,
                            input logic [srrw_pkg::TAG_W-1:0] tag, input logic end_mark);
        @(negedge i_clk);
        pkt_if.valid       = 1'b1;
        pkt_if.seq_num     = seq;
        pkt_if.payload_tag = tag;
        pkt_if.end_mark    = end_mark;
        @(posedge i_clk);
        while (pkt_if.ready !== 1'b1)
            @(posedge i_clk);
        board.take_packet(seq, tag, end_mark);
    endtask

    task automatic sender_gap(input int odds);
        int gap;
        if (!calm && odds > 0 && $urandom_range(0, odds) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            pkt_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // hold the sender until every transfer owed by the block has come out
    task automatic drain();
        @(negedge i_clk);
        pkt_if.valid = 1'b0;
        while (board.pending() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(input int value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value[srrw_pkg::COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        board.set_count(value);
    endtask

    // mostly in-window traffic around the expected number, some duplicates and strays
    task automatic pick_packet(output logic [srrw_pkg::SEQ_NUM_W-1:0] seq,
                               output logic [srrw_pkg::TAG_W-1:0] tag,
                               output logic end_mark);
        int roll;
        int base;
        int v;
        roll = $urandom_range(0, 99);
        base = board.next_seq - 1;
        if (roll < 25)
            v = base + 1;
        else if (roll < 70)
            v = (base + $urandom_range(0, 4)) % srrw_pkg::DEF_SEQ_COUNT + 1;
        else if (roll < 82)
            v = (base - $urandom_range(1, 9) + srrw_pkg::DEF_SEQ_COUNT)
                % srrw_pkg::DEF_SEQ_COUNT + 1;
        else if (roll < 91)
            v = (base + $urandom_range(5, 10)) % srrw_pkg::DEF_SEQ_COUNT + 1;
        else begin
            v = $urandom_range(20, 31);
            if (v == 20)
                v = 0;
        end
        seq      = srrw_pkg::SEQ_NUM_W'(v);
        tag      = srrw_pkg::TAG_W'($urandom);
        end_mark = ($urandom_range(0, 9) == 0);
    endtask

    task automatic run_random(input int count, input int odds);
        logic [srrw_pkg::SEQ_NUM_W-1:0] seq;
        logic [srrw_pkg::TAG_W-1:0]     tag;
        logic                           end_mark;
        for (int i = 0; i < count; i++) begin
            if (i > 0 && i % 50 == 0)
                drain();
            sender_gap(odds);
            pick_packet(seq, tag, end_mark);
            send_pkt(seq, tag, end_mark);
        end
    endtask

    initial begin
        pkt_if.valid       = 1'b0;
        pkt_if.seq_num     = '0;
        pkt_if.payload_tag = '0;
        pkt_if.end_mark    = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        i_rst_n            = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_count(255);

        // illegal numbers, zero and all-ones fields
        send_pkt(5'd0, 16'hffff, 1'b1);
        send_pkt(5'd31, 16'h0000, 1'b0);
        send_pkt(5'd21, 16'h5a5a, 1'b1);
        // out-of-order arrival, slot overwrite, then full window release
        send_pkt(5'd3, 16'h1111, 1'b0);
        send_pkt(5'd3, 16'h3333, 1'b0);
        send_pkt(5'd5, 16'h5555, 1'b0);
        send_pkt(5'd4, 16'h4444, 1'b0);
        send_pkt(5'd2, 16'h2222, 1'b0);
        send_pkt(5'd1, 16'hffff, 1'b1);
        // duplicates, halfway point and forward strays, then the window filled from the top down
        send_pkt(5'd1, 16'h0001, 1'b0);
        send_pkt(5'd16, 16'h0016, 1'b0);
        send_pkt(5'd12, 16'h0012, 1'b1);
        send_pkt(5'd17, 16'h0017, 1'b0);
        rx_odds = 0;
        send_pkt(5'd10, 16'h000a, 1'b0);
        send_pkt(5'd9, 16'h0009, 1'b0);
        send_pkt(5'd8, 16'h0008, 1'b0);
        send_pkt(5'd7, 16'h0007, 1'b0);
        send_pkt(5'd6, 16'h0006, 1'b1);
        send_pkt(5'd20, 16'hffff, 1'b0);
        // walk across the wrap from the top number back to one
        for (int s = 11; s <= 20; s++)
            send_pkt(srrw_pkg::SEQ_NUM_W'(s), srrw_pkg::TAG_W'($urandom), 1'b0);
        send_pkt(5'd2, 16'h8002, 1'b0);
        send_pkt(5'd1, 16'h8001, 1'b1);
        drain();

        rx_odds = 3;
        write_count($urandom_range(100, 200));
        run_random(120, 3);
        rx_odds = 0;
        run_random(40, 0);
        drain();

        rx_odds = 5;
        write_count(0);
        run_random(120, 5);
        calm = 1;
        run_random(70, 0);
        drain();

        repeat (20) @(posedge i_clk);
        if (board.pending() > 0)
            board.errors++;
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
